>>> rtl/vwhp_pkg.sv
// ----------------------------------------------------------------------------
// Sound header parser package
// Shared constants and command/status types for the header parser.
// ----------------------------------------------------------------------------
package vwhp_pkg;

  localparam int HEADER_BYTES = 128;
  localparam int POS_W = 9;

  localparam logic [1:0] FMT_UNKNOWN = 2'd0;
  localparam logic [1:0] FMT_VOC     = 2'd1;
  localparam logic [1:0] FMT_WAV     = 2'd2;

  localparam logic [1:0] OUT_PENDING = 2'd0;
  localparam logic [1:0] OUT_FOUND   = 2'd1;
  localparam logic [1:0] OUT_FAIL    = 2'd2;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_FMT   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

  localparam logic [31:0] VOC_RATE_NUM = 32'd1000000;
  localparam logic [31:0] WAV_DEFAULT_RATE = 32'd11025;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_byte;   // Parse the byte on the input.
    logic finish;      // Compute the result and clear the parse state.
    logic div_start;   // Load the rate divider.
    logic div_step;    // Run one divider iteration.
  } vwhp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;    // The pending result needs a VOC rate division.
    logic div_done;    // The divider has finished.
  } vwhp_sts_t;

endpackage

>>> rtl/vwhp_ctrl.sv
// ----------------------------------------------------------------------------
// Sound header parser controller
// Sequences byte intake, the optional rate division and result delivery.
// ----------------------------------------------------------------------------
module vwhp_ctrl import vwhp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output vwhp_cmd_t cmd,
  input  vwhp_sts_t sts
);

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       in_acc;

  assign in_stall  = (state_r != ST_RUN);
  assign out_valid = (state_r == ST_OUT);
  assign in_acc    = in_valid && (state_r == ST_RUN);

  // Command decode.
  always_comb begin
    cmd.take_byte = in_acc;
    cmd.finish    = in_acc && in_last;
    cmd.div_start = in_acc && in_last;
    cmd.div_step  = (state_r == ST_DIV);
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN: begin
        if (in_acc && in_last) state_nxt = sts.need_div ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_nxt = ST_RUN;
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_RUN;
    else state_r <= state_nxt;
  end

endmodule

>>> rtl/vwhp_dp.sv
// ----------------------------------------------------------------------------
// Sound header parser datapath
// Byte-wise VOC and RIFF WAVE field parsing, plus a restoring rate divider.
// ----------------------------------------------------------------------------
module vwhp_dp import vwhp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  vwhp_cmd_t   cmd,
  output vwhp_sts_t   sts,
  input  logic [7:0]  in_header_byte,
  output logic        out_found,
  output logic [1:0]  out_format_kind,
  output logic [7:0]  out_pcm_offset,
  output logic [30:0] out_pcm_len,
  output logic [31:0] out_sample_rate
);

  logic [POS_W-1:0] pos_r;
  logic [1:0]       fmt_r;
  logic [15:0]      boff_r;
  logic [POS_W-1:0] ncp_r;
  logic [1:0]       kind_r;
  logic [31:0]      shift_r;
  logic             fmtok_r;
  logic [31:0]      wrate_r;
  logic [23:0]      vsize_r;
  logic [7:0]       vdiv_r;
  logic [1:0]       outc_r;

  logic [POS_W-1:0] pos_nxt;
  logic [1:0]       fmt_nxt;
  logic [15:0]      boff_nxt;
  logic [POS_W-1:0] ncp_nxt;
  logic [1:0]       kind_nxt;
  logic [31:0]      shift_nxt;
  logic             fmtok_nxt;
  logic [31:0]      wrate_nxt;
  logic [23:0]      vsize_nxt;
  logic [7:0]       vdiv_nxt;
  logic [1:0]       outc_nxt;

  logic [7:0] b;
  logic [POS_W-1:0] pos;
  logic [16:0] rel;
  logic [16:0] ncp_e;
  logic [16:0] off_c;
  logic [16:0] foff;
  logic [33:0] nxt_chunk;
  logic [31:0] sz;
  logic [16:0] body;
  logic        fin_found;

  assign b   = in_header_byte;
  assign pos = pos_r;

  // Byte parsing: next values of the parse state.
  always_comb begin
    pos_nxt = pos_r; fmt_nxt = fmt_r; boff_nxt = boff_r; ncp_nxt = ncp_r;
    kind_nxt = kind_r; shift_nxt = shift_r; fmtok_nxt = fmtok_r;
    wrate_nxt = wrate_r; vsize_nxt = vsize_r; vdiv_nxt = vdiv_r; outc_nxt = outc_r;
    rel = 17'(pos) - 17'(boff_r);
    ncp_e = 17'(ncp_r);
    off_c = 17'(pos) - ncp_e;
    foff = 17'(pos) - 17'(boff_r);
    sz = {b, shift_r[31:8]};
    body = ncp_e + 17'd8;
    nxt_chunk = 34'(body) + 34'(sz) + 34'(sz[0]);
    if (cmd.take_byte && (32'(pos) < HEADER_BYTES)) begin
      if (pos == '0) begin
        fmt_nxt = (b == "C") ? FMT_VOC : ((b == "R") ? FMT_WAV : FMT_UNKNOWN);
        if (fmt_nxt == FMT_UNKNOWN) outc_nxt = OUT_FAIL;
      end
      if (outc_nxt == OUT_PENDING) begin
        if (fmt_nxt == FMT_VOC) begin
          // VOC block offset and block header checks.
          if (pos == POS_W'(20)) begin
            boff_nxt = {8'd0, b};
          end else if (pos == POS_W'(21)) begin
            boff_nxt = {b, boff_r[7:0]};
            if (boff_nxt < 16'd26 || 32'(boff_nxt) + 32'd6 > HEADER_BYTES
                || 32'(boff_nxt) + 32'd6 > 32'd255) outc_nxt = OUT_FAIL;
          end else if (pos >= POS_W'(22) && 16'(pos) >= boff_r) begin
            if (rel == 17'd0) begin
              if (b != 8'd1) outc_nxt = OUT_FAIL;
            end else if (rel == 17'd1) vsize_nxt[7:0] = b;
            else if (rel == 17'd2) vsize_nxt[15:8] = b;
            else if (rel == 17'd3) vsize_nxt[23:16] = b;
            else if (rel == 17'd4) vdiv_nxt = b;
            else if (rel == 17'd5) begin
              outc_nxt = (b != 8'd0 || vsize_r < 24'd3) ? OUT_FAIL : OUT_FOUND;
            end
          end
        end else if (fmt_nxt == FMT_WAV) begin
          // RIFF/WAVE tags, then the chunk walk.
          if (pos < POS_W'(4)) begin
            if (b != 8'("RIFF" >> (8 * (3 - 32'(pos))))) outc_nxt = OUT_FAIL;
          end else if (pos >= POS_W'(8) && pos < POS_W'(12)) begin
            if (b != 8'("WAVE" >> (8 * (11 - 32'(pos))))) outc_nxt = OUT_FAIL;
          end else if (pos >= POS_W'(12)) begin
            if (17'(pos) >= ncp_e && 17'(pos) < ncp_e + 17'd8
                && 32'(ncp_e) + 32'd8 <= HEADER_BYTES) begin
              if (off_c == 17'd0) begin
                kind_nxt = (b == "f") ? KIND_FMT : ((b == "d") ? KIND_DATA : KIND_OTHER);
              end else if (off_c < 17'd4) begin
                if (kind_r == KIND_FMT && b != 8'("fmt " >> (8 * (3 - 32'(off_c)))))
                  kind_nxt = KIND_OTHER;
                if (kind_r == KIND_DATA && b != 8'("data" >> (8 * (3 - 32'(off_c)))))
                  kind_nxt = KIND_OTHER;
              end else begin
                shift_nxt = sz;
                if (off_c == 17'd7) begin
                  boff_nxt = 16'(body);
                  if (kind_r == KIND_FMT && (32'(body) + 32'd16 > HEADER_BYTES
                      || sz < 32'd16)) begin
                    outc_nxt = OUT_FAIL;
                  end else if (kind_r == KIND_DATA) begin
                    outc_nxt = (!fmtok_r || sz == 32'd0 || sz[31] || body > 17'd255)
                               ? OUT_FAIL : OUT_FOUND;
                  end else if (sz[31] || nxt_chunk > 34'(HEADER_BYTES)) begin
                    ncp_nxt = POS_W'(HEADER_BYTES);
                  end else begin
                    ncp_nxt = POS_W'(nxt_chunk);
                  end
                end
              end
            end else if (kind_r == KIND_FMT && 17'(pos) >= 17'(boff_r)
                         && foff < 17'd16) begin
              case (foff[3:0])
                4'd0, 4'd2: if (b != 8'd1) outc_nxt = OUT_FAIL;
                4'd1, 4'd3: if (b != 8'd0) outc_nxt = OUT_FAIL;
                4'd4, 4'd5, 4'd6: shift_nxt = sz;
                4'd7: begin shift_nxt = sz; wrate_nxt = sz; end
                4'd14: if (b != 8'd8) outc_nxt = OUT_FAIL;
                4'd15: begin
                  if (b != 8'd0) outc_nxt = OUT_FAIL;
                  else fmtok_nxt = 1'b1;
                end
                default: ;
              endcase
            end
          end
        end
      end
      pos_nxt = pos_r + 1'b1;
    end
  end

  assign fin_found = (32'(pos_nxt) >= 32'd32) && (outc_nxt == OUT_FOUND);

  // Restoring divider for the VOC rate, one quotient bit per cycle.
  logic [31:0] dq_r;
  logic [8:0]  drem_r;
  logic [8:0]  dden_r;
  logic [5:0]  dcnt_r;
  logic [9:0]  trial;
  assign trial = {drem_r, dq_r[31]} - {1'b0, dden_r};

  // Status back to the controller.
  assign sts = '{need_div: fin_found && (fmt_nxt == FMT_VOC),
                 div_done: (dcnt_r == 6'd0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dq_r <= VOC_RATE_NUM; drem_r <= '0;
      dden_r <= 9'd256 - {1'b0, vdiv_nxt};
      dcnt_r <= sts.need_div ? 6'd32 : 6'd0;
    end else if (cmd.div_step && dcnt_r != 0) begin
      if (!trial[9]) begin
        drem_r <= trial[8:0]; dq_r <= {dq_r[30:0], 1'b1};
      end else begin
        drem_r <= {drem_r[7:0], dq_r[31]}; dq_r <= {dq_r[30:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  // Result register; the VOC rate is taken from the divider.
  logic out_voc_r;
  logic [31:0] rate_r;
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_found <= fin_found;
      out_format_kind <= fmt_nxt;
      out_voc_r <= fin_found && fmt_nxt == FMT_VOC;
      out_pcm_offset <= !fin_found ? 8'd0 :
                        (fmt_nxt == FMT_VOC ? 8'(boff_nxt + 16'd6) : boff_nxt[7:0]);
      out_pcm_len <= !fin_found ? 31'd0 :
                     (fmt_nxt == FMT_VOC ? 31'(vsize_nxt - 24'd2) : shift_nxt[30:0]);
      rate_r <= (fin_found && fmt_nxt != FMT_VOC) ? wrate_nxt : 32'd0;
    end
  end
  assign out_sample_rate = out_voc_r ? dq_r : rate_r;

  // Parse state, cleared after every result.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      pos_r <= '0; fmt_r <= FMT_UNKNOWN; boff_r <= '0; ncp_r <= POS_W'(12);
      kind_r <= KIND_OTHER; shift_r <= '0; fmtok_r <= 1'b0;
      wrate_r <= WAV_DEFAULT_RATE; vsize_r <= '0; vdiv_r <= '0; outc_r <= OUT_PENDING;
    end else begin
      pos_r <= pos_nxt; fmt_r <= fmt_nxt; boff_r <= boff_nxt; ncp_r <= ncp_nxt;
      kind_r <= kind_nxt; shift_r <= shift_nxt; fmtok_r <= fmtok_nxt;
      wrate_r <= wrate_nxt; vsize_r <= vsize_nxt; vdiv_r <= vdiv_nxt; outc_r <= outc_nxt;
    end
  end

endmodule

>>> rtl/voc_wav_header_parser_unit.sv
// One header byte is taken per cycle unless input is stalled. On the last byte
// the result appears in the next cycle for WAV files and failures, and after
// the one-bit-per-cycle rate divider finishes for a found VOC block. Input
// is stalled from the last byte until the result request is taken.
// ----------------------------------------------------------------------------
// Sound header parser top level
// Locates 8-bit mono PCM in a VOC or RIFF WAVE header.
// ----------------------------------------------------------------------------
module voc_wav_header_parser_unit import vwhp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_header_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [1:0]  out_format_kind,
  output logic [7:0]  out_pcm_offset,
  output logic [30:0] out_pcm_len,
  output logic [31:0] out_sample_rate
);

  vwhp_cmd_t cmd;
  vwhp_sts_t sts;

  vwhp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_last(in_last_byte),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .sts(sts)
  );

  vwhp_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_header_byte(in_header_byte), .out_found(out_found),
    .out_format_kind(out_format_kind), .out_pcm_offset(out_pcm_offset),
    .out_pcm_len(out_pcm_len), .out_sample_rate(out_sample_rate)
  );

endmodule

>>> rtl/vwhp_checker.sv
// ----------------------------------------------------------------------------
// Sound header parser checker
// Port-level properties of the parser's request flow.
// ----------------------------------------------------------------------------
module vwhp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_found,
  input logic [30:0] out_pcm_len
);

  // A last byte taken always brings a stall of further input.
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_byte |=> in_stall) else $error("no stall");

  // Input is never taken while a result waits.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input during result");

  // A result that is not found reports zero length.
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_pcm_len == 0) else $error("length");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pcm_len)) else $error("hold");

endmodule

bind voc_wav_header_parser_unit vwhp_checker u_chk (.*);
